// ===== design/tdrm_pkg.sv =====
// Shared types and constants for the temperature drop and recovery monitor.
// Stand-alone; used by the top level, tdrm_nearest and the dv files, not by tdrm_ram.
`timescale 1ns / 1ps

package tdrm_pkg;

    localparam int TEMP_W   = 15;
    localparam int RATE_W   = 15;
    localparam int TIME_W   = 32;
    localparam int THR_W    = 14;
    localparam int WIN_W    = 24;
    localparam int FAST_W   = 14;
    localparam int SLOW_W   = 16;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 8;
    localparam int ADDR_W   = 5;

    // rise rate of one degree per minute
    localparam logic signed [RATE_W-1:0] ONE_DEGF_PER_MIN = 15'sd16;

    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_FOOD      = 2'd1;
    localparam logic [1:0] EV_RECOVERED = 2'd2;

    localparam logic [1:0] HINT_NONE = 2'd0;
    localparam logic [1:0] HINT_FAST = 2'd1;
    localparam logic [1:0] HINT_SLOW = 2'd2;

    localparam logic [2:0] REG_ENABLED    = 3'd0;
    localparam logic [2:0] REG_TARGET_LOW = 3'd1;
    localparam logic [2:0] REG_DROP_THR   = 3'd2;
    localparam logic [2:0] REG_WINDOW     = 3'd3;
    localparam logic [2:0] REG_FAST_RATE  = 3'd4;
    localparam logic [2:0] REG_SLOW_SEC   = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EVAL,
        ST_HINT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic init;
        logic cmp;
    } scan_ctl_t;

endpackage

// ===== design/temperature_drop_recovery_monitor.sv =====
// Top level of the temperature drop and recovery monitor: sequencer, registers, decision.
// Depends on tdrm_pkg, tdrm_ram and tdrm_nearest.
//
//  port group   dir  word
//  s_*          in   tdata: temperature, rise_rate, time_ms; tuser: sample_present
//  m_*          out  tdata: in_recovery, event_code, hint_code
//  p*           cfg  APB register file, six registers at 4*i
//
// A present, enabled sample with entries stored, its own included, and no recovery running
// passes the scan, drain, eval, hint and output states; the scan reads one history entry per cycle.
// Other enabled samples skip scan and drain; disabled samples go straight to output.
// s_tready is high only while the sequencer is idle; a result still waiting holds the
// sequencer in its output state, and so the input, until the output register frees.
// Reset clears history count, head, recovery flag and registers; RAM contents are not cleared.
`timescale 1ns / 1ps

module temperature_drop_recovery_monitor #(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tdrm_pkg::S_DATA_W-1:0]     s_tdata,   // temperature, rise_rate, time_ms
    input  logic [0:0]                        s_tuser,   // sample_present
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tdrm_pkg::M_DATA_W-1:0]     m_tdata,   // in_recovery, event_code, hint_code
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tdrm_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int MW = tdrm_pkg::TEMP_W + tdrm_pkg::TIME_W;
    localparam logic [CW:0]   DEPTH_W = (CW+1)'(HISTORY_DEPTH);
    localparam logic [CW-1:0] FULL_C  = CW'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(HISTORY_DEPTH - 1);

    // configuration
    logic                                enabled_reg;
    logic signed [tdrm_pkg::TEMP_W-1:0]  target_low_reg;
    logic [tdrm_pkg::THR_W-1:0]          drop_thr_reg;
    logic [tdrm_pkg::WIN_W-1:0]          window_reg;
    logic [tdrm_pkg::FAST_W-1:0]         fast_rate_reg;
    logic [tdrm_pkg::SLOW_W-1:0]         slow_sec_reg;
    logic                                cfg_wr;

    // control state
    tdrm_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] head_reg;
    logic          recovering_reg;
    logic [CW-1:0] scan_k_reg;
    logic [AW-1:0] scan_addr_reg;
    logic          rd_vld_reg;
    logic          scan_reg;
    logic          det_reg;
    logic          m_tvalid_reg;

    // payload
    logic signed [tdrm_pkg::TEMP_W-1:0]  temp_reg;
    logic signed [tdrm_pkg::RATE_W-1:0]  rate_reg;
    logic [tdrm_pkg::TIME_W-1:0]         want_reg;
    logic signed [21:0]                  lhs_reg;
    logic signed [31:0]                  rhs_reg;
    logic                                rec_reg;
    logic [1:0]                          ev_reg;
    logic [1:0]                          hint_reg;
    logic [tdrm_pkg::M_DATA_W-1:0]       m_tdata_reg;

    // input word fields
    logic signed [tdrm_pkg::TEMP_W-1:0]  in_temp;
    logic signed [tdrm_pkg::RATE_W-1:0]  in_rate;
    logic [tdrm_pkg::TIME_W-1:0]         in_time;
    logic                                in_present;

    assign in_temp    = s_tdata[14:0];
    assign in_rate    = s_tdata[29:15];
    assign in_time    = s_tdata[61:30];
    assign in_present = s_tuser[0];

    logic accept;
    logic out_free;
    logic scan_start;
    logic scan_last;
    logic [CW:0]   slot_sum;
    logic [AW-1:0] wr_slot;
    logic [AW-1:0] head_new;
    logic [AW-1:0] head_inc;
    logic          hist_full;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign hist_full = (count_reg == FULL_C);
    assign slot_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);
    assign head_inc = (head_reg == LAST_A) ? '0 : head_reg + 1'b1;
    assign wr_slot  = hist_full ? head_reg
                    : ((slot_sum >= DEPTH_W) ? AW'(slot_sum - DEPTH_W) : AW'(slot_sum));
    assign head_new = (in_present && hist_full) ? head_inc : head_reg;
    assign scan_start = enabled_reg && in_present && !recovering_reg && (count_reg != '0);
    assign scan_last  = (scan_k_reg == count_reg - 1'b1);

    // history store
    logic          ram_we;
    logic          ram_re;
    logic [MW-1:0] ram_rdata;

    tdrm_ram #(
        .WIDTH (MW),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wr_slot),
        .wdata ({in_time, in_temp}),
        .re    (ram_re),
        .raddr (scan_addr_reg),
        .rdata (ram_rdata)
    );

    tdrm_pkg::scan_ctl_t               scan_ctl;
    logic signed [tdrm_pkg::TEMP_W-1:0] best_temp;

    assign scan_ctl.init = accept;
    assign scan_ctl.cmp  = rd_vld_reg;

    tdrm_nearest u_nearest (
        .aclk      (aclk),
        .ctl       (scan_ctl),
        .want      (want_reg),
        .cur_temp  (in_temp),
        .rd_time   (ram_rdata[MW-1:tdrm_pkg::TEMP_W]),
        .rd_temp   (ram_rdata[tdrm_pkg::TEMP_W-1:0]),
        .best_temp (best_temp)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tdrm_pkg::ST_IDLE: begin
                if (accept) begin
                    if (!enabled_reg) begin
                        state_next = tdrm_pkg::ST_OUT;
                    end else if (scan_start) begin
                        state_next = tdrm_pkg::ST_SCAN;
                    end else begin
                        state_next = tdrm_pkg::ST_EVAL;
                    end
                end
            end
            tdrm_pkg::ST_SCAN: begin
                if (scan_last) begin
                    state_next = tdrm_pkg::ST_DRAIN;
                end
            end
            tdrm_pkg::ST_DRAIN: state_next = tdrm_pkg::ST_EVAL;
            tdrm_pkg::ST_EVAL:  state_next = tdrm_pkg::ST_HINT;
            tdrm_pkg::ST_HINT:  state_next = tdrm_pkg::ST_OUT;
            tdrm_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = tdrm_pkg::ST_IDLE;
                end
            end
            default: state_next = tdrm_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        case (state_reg)
            tdrm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                ram_we   = s_tvalid && enabled_reg && in_present;
            end
            tdrm_pkg::ST_SCAN: ram_re = 1'b1;
            default: ;
        endcase
    end

    // decision datapath
    logic signed [15:0] drop;
    logic signed [15:0] diff;
    logic               warm;
    logic               rec_eff;
    logic [1:0]         ev_calc;
    logic [1:0]         hint_calc;

    assign drop    = 16'(best_temp) - 16'(temp_reg);
    assign diff    = 16'(target_low_reg) - 16'(temp_reg);
    assign warm    = (temp_reg >= target_low_reg);
    assign rec_eff = recovering_reg || det_reg;

    always_comb begin
        ev_calc   = det_reg ? tdrm_pkg::EV_FOOD : tdrm_pkg::EV_NONE;
        hint_calc = tdrm_pkg::HINT_NONE;
        if (rec_eff) begin
            if (warm) begin
                ev_calc = tdrm_pkg::EV_RECOVERED;
            end else if (rate_reg > $signed({1'b0, fast_rate_reg})) begin
                hint_calc = tdrm_pkg::HINT_FAST;
            end else if (rate_reg > tdrm_pkg::ONE_DEGF_PER_MIN) begin
                if (32'(lhs_reg) > rhs_reg) begin
                    hint_calc = tdrm_pkg::HINT_SLOW;
                end
            end else begin
                hint_calc = tdrm_pkg::HINT_SLOW;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= tdrm_pkg::ST_IDLE;
            count_reg      <= '0;
            head_reg       <= '0;
            recovering_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            scan_reg       <= 1'b0;
            det_reg        <= 1'b0;
            scan_k_reg     <= '0;
            scan_addr_reg  <= '0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == tdrm_pkg::ST_SCAN);
            if ((state_reg == tdrm_pkg::ST_OUT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                tdrm_pkg::ST_IDLE: begin
                    if (accept) begin
                        scan_reg      <= scan_start;
                        scan_k_reg    <= '0;
                        scan_addr_reg <= head_new;
                        if (!enabled_reg) begin
                            count_reg      <= '0;
                            head_reg       <= '0;
                            recovering_reg <= 1'b0;
                        end else if (in_present) begin
                            head_reg <= head_new;
                            if (!hist_full) begin
                                count_reg <= count_reg + 1'b1;
                            end
                        end
                    end
                end
                tdrm_pkg::ST_SCAN: begin
                    scan_k_reg    <= scan_k_reg + 1'b1;
                    scan_addr_reg <= (scan_addr_reg == LAST_A) ? '0 : scan_addr_reg + 1'b1;
                end
                tdrm_pkg::ST_EVAL: begin
                    det_reg <= scan_reg && (drop >= $signed({2'b00, drop_thr_reg}));
                end
                tdrm_pkg::ST_HINT: begin
                    det_reg <= 1'b0;
                    if (rec_eff) begin
                        recovering_reg <= !warm;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            temp_reg <= in_temp;
            rate_reg <= in_rate;
            want_reg <= in_time - tdrm_pkg::TIME_W'(window_reg);
            rec_reg  <= 1'b0;
            ev_reg   <= tdrm_pkg::EV_NONE;
            hint_reg <= tdrm_pkg::HINT_NONE;
        end
        if (state_reg == tdrm_pkg::ST_EVAL) begin
            lhs_reg <= {diff, 6'b0} - {{4{diff[15]}}, diff, 2'b0};
            rhs_reg <= 32'($signed({1'b0, slow_sec_reg})) * 32'(rate_reg);
        end
        if (state_reg == tdrm_pkg::ST_HINT) begin
            rec_reg  <= rec_eff;
            ev_reg   <= ev_calc;
            hint_reg <= hint_calc;
        end
        if ((state_reg == tdrm_pkg::ST_OUT) && out_free) begin
            m_tdata_reg <= {3'b000, hint_reg, ev_reg, rec_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg    <= 1'b0;
            target_low_reg <= '0;
            drop_thr_reg   <= 14'd432;
            window_reg     <= 24'd30000;
            fast_rate_reg  <= 14'd480;
            slow_sec_reg   <= 16'd120;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                tdrm_pkg::REG_ENABLED:    enabled_reg    <= pwdata[0];
                tdrm_pkg::REG_TARGET_LOW: target_low_reg <= pwdata[14:0];
                tdrm_pkg::REG_DROP_THR:   drop_thr_reg   <= pwdata[13:0];
                tdrm_pkg::REG_WINDOW:     window_reg     <= pwdata[23:0];
                tdrm_pkg::REG_FAST_RATE:  fast_rate_reg  <= pwdata[13:0];
                tdrm_pkg::REG_SLOW_SEC:   slow_sec_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            tdrm_pkg::REG_ENABLED:    prdata = {31'b0, enabled_reg};
            tdrm_pkg::REG_TARGET_LOW: prdata = {17'b0, target_low_reg};
            tdrm_pkg::REG_DROP_THR:   prdata = {18'b0, drop_thr_reg};
            tdrm_pkg::REG_WINDOW:     prdata = {8'b0, window_reg};
            tdrm_pkg::REG_FAST_RATE:  prdata = {18'b0, fast_rate_reg};
            tdrm_pkg::REG_SLOW_SEC:   prdata = {16'b0, slow_sec_reg};
            default:                  prdata = 32'b0;
        endcase
    end

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_C)
        else $error("history count beyond depth");

    a_disable_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !enabled_reg) |=> (count_reg == '0) && !recovering_reg)
        else $error("disabled word did not clear state");

    a_food_in_rec: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[2:1] == tdrm_pkg::EV_FOOD)) |-> m_tdata[0])
        else $error("food event outside recovery");

    a_hint_in_rec: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[4:3] != tdrm_pkg::HINT_NONE)) |->
            (m_tdata[0] && (m_tdata[2:1] != tdrm_pkg::EV_RECOVERED)))
        else $error("hint given outside active recovery");

endmodule

// ===== design/tdrm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tdrm_ram #(
    parameter int WIDTH = 47,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tdrm_nearest.sv =====
// Distance and compare unit: tracks the stored sample nearest the lookback time.
// Depends on tdrm_pkg.
`timescale 1ns / 1ps

module tdrm_nearest (
    input  logic                                    aclk,
    input  tdrm_pkg::scan_ctl_t                     ctl,
    input  logic [tdrm_pkg::TIME_W-1:0]             want,
    input  logic signed [tdrm_pkg::TEMP_W-1:0]      cur_temp,
    input  logic [tdrm_pkg::TIME_W-1:0]             rd_time,
    input  logic signed [tdrm_pkg::TEMP_W-1:0]      rd_temp,
    output logic signed [tdrm_pkg::TEMP_W-1:0]      best_temp
);

    logic [tdrm_pkg::TIME_W-1:0]        best_dist_reg;
    logic signed [tdrm_pkg::TEMP_W-1:0] best_temp_reg;
    logic [tdrm_pkg::TIME_W-1:0]        time_gap;

    assign time_gap = (rd_time > want) ? (rd_time - want) : (want - rd_time);

    // no qualifying entry leaves the newest one, which is the current sample
    always_ff @(posedge aclk) begin
        if (ctl.init) begin
            best_dist_reg <= '1;
            best_temp_reg <= cur_temp;
        end else if (ctl.cmp && (time_gap < best_dist_reg)) begin
            best_dist_reg <= time_gap;
            best_temp_reg <= rd_temp;
        end
    end

    assign best_temp = best_temp_reg;

endmodule

// ===== dv/tdrm_checker.sv =====
// Scoreboard for the temperature drop and recovery monitor: tracks APB writes, predicts
// one result word per accepted sample and compares it with the result channel.
// Depends on tdrm_pkg.
`timescale 1ns / 1ps

module tdrm_checker #(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [tdrm_pkg::S_DATA_W-1:0]     s_tdata,   // temperature, rise_rate, time_ms
    input  logic [0:0]                        s_tuser,   // sample_present
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [tdrm_pkg::M_DATA_W-1:0]     m_tdata,   // in_recovery, event_code, hint_code
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tdrm_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    input  logic                              pready,
    output int                                errors,
    output int                                pending,
    output int                                food_events,
    output int                                recovered_events
);

    localparam int SEC_PER_MIN = 60;
    localparam int TEMP_W = tdrm_pkg::TEMP_W;
    localparam int RATE_W = tdrm_pkg::RATE_W;
    localparam int TIME_W = tdrm_pkg::TIME_W;

    typedef struct packed {
        logic       in_rec;
        logic [1:0] ev;
        logic [1:0] hint;
    } status_t;

    logic signed [TEMP_W-1:0] ring_temp [HISTORY_DEPTH];
    logic [TIME_W-1:0]        ring_time [HISTORY_DEPTH];
    int unsigned              ring_fill;
    int unsigned              ring_oldest;
    logic                     climbing;

    logic                          mon_on;
    logic signed [TEMP_W-1:0]      band_low;
    logic [tdrm_pkg::THR_W-1:0]    drop_min;
    logic [tdrm_pkg::WIN_W-1:0]    lookback;
    logic [tdrm_pkg::FAST_W-1:0]   fast_lim;
    logic [tdrm_pkg::SLOW_W-1:0]   slow_lim;

    status_t                  status_queue [$];
    int                       err_cnt;
    int                       food_cnt;
    int                       recov_cnt;

    function automatic logic signed [TEMP_W-1:0] lookback_temp(
        input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0]        target;
        logic [TIME_W-1:0]        ts;
        logic [TIME_W-1:0]        gap;
        logic [TIME_W-1:0]        best_dist;
        logic signed [TEMP_W-1:0] best;
        logic                     found;
        int unsigned              idx;
        target    = now - TIME_W'(lookback);
        best_dist = '1;
        best      = '0;
        found     = 1'b0;
        for (int unsigned k = 0; k < ring_fill; k++) begin
            idx = (ring_oldest + k) % HISTORY_DEPTH;
            ts  = ring_time[idx];
            gap = (ts > target) ? ts - target : target - ts;
            if (gap < best_dist) begin
                best_dist = gap;
                best      = ring_temp[idx];
                found     = 1'b1;
            end
        end
        if (!found)
            best = ring_temp[(ring_oldest + ring_fill + HISTORY_DEPTH - 1) % HISTORY_DEPTH];
        return best;
    endfunction

    function automatic status_t judge_sample(input logic signed [TEMP_W-1:0] temp,
                                             input logic signed [RATE_W-1:0] rate,
                                             input logic present,
                                             input logic [TIME_W-1:0] now);
        status_t     st;
        int unsigned slot;
        longint      behind;
        longint      budget;
        st = '0;
        if (!mon_on) begin
            ring_fill   = 0;
            ring_oldest = 0;
            climbing    = 1'b0;
            return st;
        end
        if (present) begin
            if (ring_fill < HISTORY_DEPTH) begin
                slot = (ring_oldest + ring_fill) % HISTORY_DEPTH;
                ring_fill++;
            end else begin
                slot        = ring_oldest;
                ring_oldest = (ring_oldest + 1) % HISTORY_DEPTH;
            end
            ring_temp[slot] = temp;
            ring_time[slot] = now;
        end
        if (!climbing && present && ring_fill >= 2) begin
            if (int'(lookback_temp(now)) - int'(temp) >= int'(drop_min)) begin
                climbing = 1'b1;
                st.ev    = tdrm_pkg::EV_FOOD;
            end
        end
        if (climbing) begin
            st.in_rec = 1'b1;
            if (temp >= band_low) begin
                climbing = 1'b0;
                st.ev    = tdrm_pkg::EV_RECOVERED;
            end else if (int'(rate) > int'(fast_lim)) begin
                st.hint = tdrm_pkg::HINT_FAST;
            end else if (rate > tdrm_pkg::ONE_DEGF_PER_MIN) begin
                behind = longint'(int'(band_low) - int'(temp)) * SEC_PER_MIN;
                budget = longint'(slow_lim) * longint'(rate);
                if (behind > budget)
                    st.hint = tdrm_pkg::HINT_SLOW;
            end else begin
                st.hint = tdrm_pkg::HINT_SLOW;
            end
        end
        return st;
    endfunction

    always @(posedge aclk) begin
        status_t st;
        status_t exp_st;
        if (!aresetn) begin
            ring_fill   = 0;
            ring_oldest = 0;
            climbing    = 1'b0;
            mon_on      = 1'b0;
            band_low    = '0;
            drop_min    = 14'd432;
            lookback    = 24'd30000;
            fast_lim    = 14'd480;
            slow_lim    = 16'd120;
            status_queue.delete();
            err_cnt     = 0;
            food_cnt    = 0;
            recov_cnt   = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[tdrm_pkg::ADDR_W-1:2])
                    tdrm_pkg::REG_ENABLED:    mon_on   = pwdata[0];
                    tdrm_pkg::REG_TARGET_LOW: band_low = pwdata[TEMP_W-1:0];
                    tdrm_pkg::REG_DROP_THR:   drop_min = pwdata[tdrm_pkg::THR_W-1:0];
                    tdrm_pkg::REG_WINDOW:     lookback = pwdata[tdrm_pkg::WIN_W-1:0];
                    tdrm_pkg::REG_FAST_RATE:  fast_lim = pwdata[tdrm_pkg::FAST_W-1:0];
                    tdrm_pkg::REG_SLOW_SEC:   slow_lim = pwdata[tdrm_pkg::SLOW_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                st = judge_sample(s_tdata[TEMP_W-1:0],
                                  s_tdata[TEMP_W+RATE_W-1:TEMP_W],
                                  s_tuser[0],
                                  s_tdata[TEMP_W+RATE_W+TIME_W-1:TEMP_W+RATE_W]);
                if (st.ev == tdrm_pkg::EV_FOOD)
                    food_cnt++;
                if (st.ev == tdrm_pkg::EV_RECOVERED)
                    recov_cnt++;
                status_queue.push_back(st);
            end
            if (m_tvalid && m_tready) begin
                if (status_queue.size() == 0) begin
                    $error("result word 0x%0h with no sample waiting", m_tdata);
                    err_cnt++;
                end else begin
                    exp_st = status_queue.pop_front();
                    if (m_tdata[0] !== exp_st.in_rec) begin
                        $error("in_recovery: expected %0d, got %0d", exp_st.in_rec, m_tdata[0]);
                        err_cnt++;
                    end
                    if (m_tdata[2:1] !== exp_st.ev) begin
                        $error("event_code: expected %0d, got %0d", exp_st.ev, m_tdata[2:1]);
                        err_cnt++;
                    end
                    if (m_tdata[4:3] !== exp_st.hint) begin
                        $error("hint_code: expected %0d, got %0d", exp_st.hint, m_tdata[4:3]);
                        err_cnt++;
                    end
                end
            end
        end
        errors           <= err_cnt;
        pending          <= status_queue.size();
        food_events      <= food_cnt;
        recovered_events <= recov_cnt;
    end

endmodule

// ===== dv/temperature_drop_recovery_monitor_tb.sv =====
// Testbench top for the temperature drop and recovery monitor: clock, reset, APB set-up,
// directed and random sample streams, handshake pressure and the verdict.
// Depends on tdrm_pkg, tdrm_checker and the block itself.
`timescale 1ns / 1ps

module temperature_drop_recovery_monitor_tb;

    localparam int DEPTH          = 64;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 210;
    localparam int DISABLED_ITEMS = 30;
    localparam int HOLD_CYCLES    = 1500;
    localparam int TAIL_CYCLES    = 80;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int TEMP_W         = tdrm_pkg::TEMP_W;
    localparam int RATE_W         = tdrm_pkg::RATE_W;
    localparam int TIME_W         = tdrm_pkg::TIME_W;
    localparam int S_DATA_W       = tdrm_pkg::S_DATA_W;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [S_DATA_W-1:0]           s_tdata  = '0;   // temperature, rise_rate, time_ms
    logic [0:0]                    s_tuser  = '0;   // sample_present
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [tdrm_pkg::M_DATA_W-1:0] m_tdata;         // in_recovery, event_code, hint_code
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [tdrm_pkg::ADDR_W-1:0]   paddr    = '0;
    logic [31:0]                   pwdata   = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    int                    errors;
    int                    pending;
    int                    food_events;
    int                    recovered_events;

    int                    idle_pct   = 0;
    int                    stall_pct  = 0;
    logic                  hold_req   = 1'b0;
    logic                  hold_done  = 1'b0;
    int                    hold_left  = 0;
    int                    cycles     = 0;
    int                    n_sent     = 0;
    int                    n_cfgs     = 0;

    int                    base_temp;
    int                    cur_temp;
    logic [TIME_W-1:0]     cur_time;
    int unsigned           step_max;
    int unsigned           step_fix;
    int                    g_thr;
    int                    g_fast;

    temperature_drop_recovery_monitor #(.HISTORY_DEPTH(DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tdrm_checker #(.HISTORY_DEPTH(DEPTH)) scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .errors(errors), .pending(pending),
        .food_events(food_events), .recovered_events(recovered_events)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // hold the result channel off once for a long stretch, else stall at random
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_sample(input int temp, input int rate, input bit present,
                               input logic [TIME_W-1:0] now);
        logic [TEMP_W-1:0] t;
        logic [RATE_W-1:0] r;
        t = temp[TEMP_W-1:0];
        r = rate[RATE_W-1:0];
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-TIME_W-RATE_W-TEMP_W){1'b0}}, now, r, t};
        s_tuser  <= present;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        n_sent++;
    endtask

    task automatic drain_and_wait();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_cfg(input bit en, input int tgt, input int thr, input int win,
                             input int fast, input int slow);
        drain_and_wait();
        write_reg(tdrm_pkg::REG_TARGET_LOW, tgt);
        write_reg(tdrm_pkg::REG_DROP_THR, thr);
        write_reg(tdrm_pkg::REG_WINDOW, win);
        write_reg(tdrm_pkg::REG_FAST_RATE, fast);
        write_reg(tdrm_pkg::REG_SLOW_SEC, slow);
        write_reg(tdrm_pkg::REG_ENABLED, 32'(en));
        g_thr  = thr;
        g_fast = fast;
        n_cfgs++;
    endtask

    // mostly a cooking session: steady, sudden drops, climbs; some raw noise
    task automatic send_random();
        int          r;
        int          rate;
        int unsigned pick;
        bit          present;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            send_sample($urandom, $urandom, 1'($urandom_range(0, 1)), $urandom);
        end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                cur_time += 0;
            else if (pick < 5)
                cur_time += step_fix;
            else
                cur_time += $urandom_range(1, step_max);
            if (r < 14)
                cur_temp -= g_thr + int'($urandom_range(0, 600));
            else if (r < 17)
                cur_temp = base_temp + int'($urandom_range(0, 200)) - 100;
            else
                cur_temp += int'($urandom_range(0, 60)) - 20;
            if (cur_temp > 16383)
                cur_temp = 16383;
            if (cur_temp < -16384)
                cur_temp = -16384;
            case ($urandom_range(0, 4))
                0:       rate = g_fast + 1 + int'($urandom_range(0, 300));
                1:       rate = int'($urandom_range(17, 700));
                2:       rate = int'($urandom_range(0, 56)) - 40;
                3:       rate = 16 + int'($urandom_range(0, 1));
                default: rate = int'($urandom_range(0, 32767)) - 16384;
            endcase
            if (rate > 16383)
                rate = 16383;
            present = ($urandom_range(0, 9) != 0);
            send_sample(cur_temp, rate, present, cur_time);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // disabled after reset: all-zero words
        send_sample(3000, 100, 1'b1, 32'd0);
        send_sample(-500, -100, 1'b0, 32'd10);

        apply_cfg(1'b1, 2000, 432, 30000, 480, 120);
        send_sample(3000, 0, 1'b1, 32'd0);
        send_sample(0, 0, 1'b0, 32'd1000);
        send_sample(3000, 0, 1'b1, 32'd30000);
        send_sample(2400, 0, 1'b1, 32'd31000);
        send_sample(1000, 500, 1'b1, 32'd32000);
        send_sample(1200, 300, 1'b0, 32'd33000);
        send_sample(1500, 400, 1'b0, 32'd34000);
        send_sample(1600, 16, 1'b1, 32'd35000);
        send_sample(1700, -16384, 1'b0, 32'd36000);
        send_sample(1800, 16383, 1'b1, 32'd37000);
        send_sample(2000, 17, 1'b1, 32'd38000);
        // equidistant neighbours: the earlier one, with no drop, must win
        send_sample(5000, 0, 1'b1, 32'd40000);
        send_sample(1700, 0, 1'b1, 32'd69000);
        send_sample(-16384, -16384, 1'b1, 32'hFFFF_FFFF);
        send_sample(16383, 16383, 1'b1, 32'd0);
        send_sample(-16384, 0, 1'b1, 32'd30000);
        send_sample(16383, 0, 1'b0, 32'd31000);

        // clear the history, then every stored entry at the worst distance
        apply_cfg(1'b0, 2000, 432, 30000, 480, 120);
        send_sample(0, 0, 1'b1, 32'd0);
        apply_cfg(1'b1, 2000, 0, 1, 480, 120);
        send_sample(50, 0, 1'b1, 32'd0);
        send_sample(100, 0, 1'b1, 32'd0);
        send_sample(3000, 0, 1'b1, 32'd5);

        for (int ph = 0; ph < PHASES; ph++) begin
            base_temp = int'($urandom_range(0, 6000)) - 2000;
            cur_temp  = base_temp;
            cur_time  = (ph == 6) ? 32'hFFFF_0000 : $urandom;
            step_max  = $urandom_range(50, 5000);
            step_fix  = $urandom_range(1, step_max);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 53; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            case (ph)
                1: apply_cfg(1'b1, -16384, 16383, 16777215, 16383, 65535);
                2: apply_cfg(1'b1, 16383, 0, 0, 0, 0);
                default: apply_cfg(ph != 3, base_temp - int'($urandom_range(0, 300)),
                                   $urandom_range(0, 1200), $urandom_range(0, 20000),
                                   $urandom_range(0, 1000), $urandom_range(0, 600));
            endcase
            if (ph == 2)
                hold_req <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 3 && n == DISABLED_ITEMS) begin
                    drain_and_wait();
                    write_reg(tdrm_pkg::REG_ENABLED, 1);
                end
                if (ph == 5 && n == PHASE_ITEMS / 2)
                    drain_and_wait();
                send_random();
            end
        end

        drain_and_wait();
        $display("covered %0d samples over %0d register settings, idle and stall mixes",
                 n_sent, n_cfgs);
        $display("predicted %0d food-added and %0d recovered events", food_events,
                 recovered_events);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
